[rtl/qau_pkg.sv]
package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_BITS = 2 * WORD_BITS + 3;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_SCL  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;
  localparam logic [2:0] OP_LEN  = 3'd6;
  localparam logic [2:0] OP_LEN2 = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } qau_in_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               overflow;
    logic               zero_length;
  } qau_out_t;

  // item class worked out at the front
  typedef struct packed {
    logic ham;
    logic need_sqrt;
  } qau_cls_t;

  typedef struct packed {
    qau_in_t  item;
    qau_cls_t cls;
  } qau_entry_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       sub;
  } qau_term_t;

  // Hamilton product: term i of component k at index 4*k+i
  function automatic qau_term_t ham_term(input logic [3:0] idx);
    qau_term_t t;
    unique case (idx)
      4'd0:    t = '{2'd0, 2'd0, 1'b0};
      4'd1:    t = '{2'd1, 2'd1, 1'b1};
      4'd2:    t = '{2'd2, 2'd2, 1'b1};
      4'd3:    t = '{2'd3, 2'd3, 1'b1};
      4'd4:    t = '{2'd0, 2'd1, 1'b0};
      4'd5:    t = '{2'd1, 2'd0, 1'b0};
      4'd6:    t = '{2'd2, 2'd3, 1'b0};
      4'd7:    t = '{2'd3, 2'd2, 1'b1};
      4'd8:    t = '{2'd0, 2'd2, 1'b0};
      4'd9:    t = '{2'd2, 2'd0, 1'b0};
      4'd10:   t = '{2'd1, 2'd3, 1'b1};
      4'd11:   t = '{2'd3, 2'd1, 1'b0};
      4'd12:   t = '{2'd0, 2'd3, 1'b0};
      4'd13:   t = '{2'd3, 2'd0, 1'b0};
      4'd14:   t = '{2'd1, 2'd2, 1'b0};
      default: t = '{2'd2, 2'd1, 1'b1};
    endcase
    return t;
  endfunction

  // {overflow, clamped word}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (WORD_BITS - 1)) - WIDE_BITS'(1);
    lo = -(WIDE_BITS'(1) <<< (WORD_BITS - 1));
    if (v > hi) return {1'b1, hi[WORD_BITS-1:0]};
    else if (v < lo) return {1'b1, lo[WORD_BITS-1:0]};
    else return {1'b0, v[WORD_BITS-1:0]};
  endfunction

  // drop fraction bits, round half up
  function automatic logic signed [WIDE_BITS-1:0] round_frac(
      input logic signed [WIDE_BITS-2:0] v);
    logic signed [WIDE_BITS-1:0] t;
    t = {v[WIDE_BITS-2], v} + (WIDE_BITS'(1) <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

endpackage

[rtl/qau_front.sv]
module qau_front import qau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  qau_in_t    item_i,
  input  logic       pop_i,
  output logic       avail_o,
  output qau_entry_t entry_o
);

  qau_entry_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  qau_cls_t   cls;

  always_comb begin
    cls.ham       = (item_i.op == OP_MUL);
    cls.need_sqrt = (item_i.op == OP_NORM) || (item_i.op == OP_LEN);
  end

  assign busy_o  = cnt_q[1];
  assign avail_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rd_q];
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && avail_o;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{item: item_i, cls: cls};
  end

endmodule

[rtl/qau_back.sv]
module qau_back import qau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  qau_entry_t entry_i,
  output logic       pop_o,
  output logic       valid_o,
  output qau_out_t   result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_RFIX  = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  qau_in_t    item_q;
  qau_cls_t   cls_q;

  logic signed [31:0] a_arr [4];
  logic signed [31:0] b_arr [4];

  // multiplier stage
  logic signed [31:0] mx, my;
  logic signed [63:0] mp_q;
  logic               mv_q;
  logic [2:0]         mtgt_q, mtgt_d;
  logic               msub_q, msub_d;
  qau_term_t          term;

  logic signed [65:0] acc_q [4];
  logic signed [65:0] sq_q;
  logic signed [65:0] mext;

  // square root
  logic [65:0] sh_q;
  logic [35:0] rem_q, remn, trial;
  logic [33:0] root_q, f_q;
  logic        sge;

  // dividers, one lane per component
  logic [63:0] num_q  [4];
  logic [35:0] drem_q [4];
  logic [63:0] quo_q  [4];
  logic [3:0]  neg_q;
  logic [34:0] dvs_q;

  logic     out_v_q;
  qau_out_t out_q, out_d;
  logic [5:0] last;

  assign a_arr = '{item_q.a_w, item_q.a_x, item_q.a_y, item_q.a_z};
  assign b_arr = '{item_q.b_w, item_q.b_x, item_q.b_y, item_q.b_z};

  assign pop_o    = (state_q == S_IDLE) && avail_i;
  assign valid_o  = out_v_q;
  assign result_o = out_q;
  assign last     = cls_q.ham ? 6'd15 : 6'd7;

  always_comb begin
    term   = ham_term(cnt_q[3:0]);
    mx     = a_arr[cnt_q[1:0]];
    my     = cnt_q[2] ? item_q.scalar_in : a_arr[cnt_q[1:0]];
    mtgt_d = cnt_q[2] ? {1'b0, cnt_q[1:0]} : 3'd4;
    msub_d = 1'b0;
    if (cls_q.ham) begin
      mx     = a_arr[term.ai];
      my     = b_arr[term.bi];
      mtgt_d = {1'b0, cnt_q[3:2]};
      msub_d = term.sub;
    end
  end

  assign mext  = {{2{mp_q[63]}}, mp_q};
  assign remn  = {rem_q[33:0], sh_q[65:64]};
  assign trial = {root_q, 2'b01};
  assign sge   = (remn >= trial);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = 6'd0;
        if (avail_i) state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == last) state_d = S_ACC;
      end
      S_ACC: begin
        cnt_d   = 6'd0;
        state_d = cls_q.need_sqrt ? S_SQRT : S_OUT;
      end
      S_SQRT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) state_d = S_RFIX;
      end
      S_RFIX: state_d = S_DINIT;
      S_DINIT: begin
        cnt_d   = 6'd0;
        state_d = (item_q.op == OP_NORM && f_q != '0) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = S_OUT;
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result formatting
  always_comb begin
    logic [WORD_BITS:0]         s [4];
    logic [WORD_BITS:0]         so;
    logic signed [WIDE_BITS-1:0] qv;
    for (int i = 0; i < 4; i++) s[i] = '0;
    so    = '0;
    out_d = '0;
    qv    = '0;
    unique case (item_q.op)
      OP_ADD: begin
        for (int i = 0; i < 4; i++)
          s[i] = sat_word(WIDE_BITS'(a_arr[i]) + WIDE_BITS'(b_arr[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++)
          s[i] = sat_word(WIDE_BITS'(a_arr[i]) - WIDE_BITS'(b_arr[i]));
      end
      OP_MUL, OP_SCL: begin
        for (int i = 0; i < 4; i++) s[i] = sat_word(round_frac(acc_q[i]));
      end
      OP_CONJ: begin
        s[0] = sat_word(WIDE_BITS'(a_arr[0]));
        for (int i = 1; i < 4; i++) s[i] = sat_word(-WIDE_BITS'(a_arr[i]));
      end
      OP_NORM: begin
        if (f_q == '0) begin
          for (int i = 0; i < 4; i++) s[i] = {1'b0, a_arr[i]};
          out_d.zero_length = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            qv   = {3'b000, quo_q[i]};
            s[i] = sat_word(neg_q[i] ? -qv : qv);
          end
        end
      end
      OP_LEN:  so = sat_word({33'd0, f_q});
      default: so = sat_word(round_frac(sq_q));
    endcase
    out_d.r_w        = s[0][WORD_BITS-1:0];
    out_d.r_x        = s[1][WORD_BITS-1:0];
    out_d.r_y        = s[2][WORD_BITS-1:0];
    out_d.r_z        = s[3][WORD_BITS-1:0];
    out_d.scalar_out = so[WORD_BITS-1:0];
    out_d.overflow   = s[0][WORD_BITS] | s[1][WORD_BITS] | s[2][WORD_BITS]
                     | s[3][WORD_BITS] | so[WORD_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= (state_q == S_MUL);
      out_v_q <= (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= entry_i.item;
      cls_q  <= entry_i.cls;
      sq_q   <= '0;
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end else if (mv_q) begin
      if (mtgt_q == 3'd4) sq_q <= sq_q + mext;
      else if (msub_q) acc_q[mtgt_q[1:0]] <= acc_q[mtgt_q[1:0]] - mext;
      else acc_q[mtgt_q[1:0]] <= acc_q[mtgt_q[1:0]] + mext;
    end

    mp_q   <= mx * my;
    mtgt_q <= mtgt_d;
    msub_q <= msub_d;

    if (state_q == S_ACC) begin
      sh_q   <= sq_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == S_SQRT) begin
      sh_q   <= {sh_q[63:0], 2'b00};
      rem_q  <= sge ? remn - trial : remn;
      root_q <= {root_q[32:0], sge};
    end

    if (state_q == S_RFIX)
      f_q <= root_q + {33'd0, (rem_q > {2'b00, root_q})};

    if (state_q == S_DINIT) begin
      dvs_q <= {f_q, 1'b0};
      for (int i = 0; i < 4; i++) begin
        neg_q[i]  <= acc_q[i][65];
        num_q[i]  <= {(acc_q[i][65] ? 63'(-acc_q[i]) : 63'(acc_q[i])), 1'b0}
                   + {30'd0, f_q};
        drem_q[i] <= '0;
        quo_q[i]  <= '0;
      end
    end else if (state_q == S_DIV) begin
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= {num_q[i][62:0], 1'b0};
        if ({drem_q[i][34:0], num_q[i][63]} >= {1'b0, dvs_q}) begin
          drem_q[i] <= {drem_q[i][34:0], num_q[i][63]} - {1'b0, dvs_q};
          quo_q[i]  <= {quo_q[i][62:0], 1'b1};
        end else begin
          drem_q[i] <= {drem_q[i][34:0], num_q[i][63]};
          quo_q[i]  <= {quo_q[i][62:0], 1'b0};
        end
      end
    end

    if (state_q == S_OUT) out_q <= out_d;
  end

endmodule

[rtl/quaternion_arithmetic_unit.sv]
// One word in flight: the engine takes a new word from the queue only once the last is through.
// Its pace is set by the shared 32x32 multiplier (8 products, or 16 for the Hamilton product),
// the 2-bit-per-cycle square root (33 steps) for length and normalize, and the 1-bit-per-cycle
// dividers (64 steps) for normalize of a nonzero length. Two-word input queue; busy when full.
// Reset (rst_ni low, async) empties the queue and idles the engine; results cannot stall.
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  qau_in_t  item_i,
  output logic     valid_o,
  output qau_out_t result_o
);

  logic       pop, avail;
  qau_entry_t entry;

  qau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .item_i  (item_i),
    .pop_i   (pop),
    .avail_o (avail),
    .entry_o (entry)
  );

  qau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .entry_i  (entry),
    .pop_o    (pop),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

[sim/quaternion_arithmetic_unit_test.sv]
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_test;
  import qau_pkg::*;

  localparam int MAX_LATENCY = 120;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  qau_in_t  item_i;
  logic     valid_o;
  qau_out_t result_o;

  qau_out_t expected_q[$];
  int       errors;
  int       send_idle_pct;

  quaternion_arithmetic_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // clamp a wide value to 32 bits, flagging overflow
  function automatic logic signed [31:0] clamp32(input logic signed [199:0] v, inout logic ov);
    if (v > 200'sh7fffffff) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -200'sh80000000) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [199:0] round_half_up(input logic signed [199:0] v);
    return (v + 200'sd32768) >>> 16;
  endfunction

  // rounded integer square root of a nonnegative value
  function automatic logic [199:0] round_sqrt(input logic [199:0] s);
    logic [199:0] lo, hi, mid;
    lo = 0;
    hi = 200'd1 << 97;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    // round: compare s with (lo + 1/2)^2 = lo^2 + lo + 1/4
    if (s - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  function automatic qau_out_t quat_result(input qau_in_t w);
    qau_out_t r;
    logic signed [199:0] a[4], b[4], acc, p, sq, f, q;
    logic ov;
    logic neg;
    int ai[16], bi[16], sb[16];
    ai = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 2, 1, 3, 0, 3, 1, 2};
    bi = '{0, 1, 2, 3, 1, 0, 3, 2, 2, 0, 3, 1, 3, 0, 2, 1};
    sb = '{0, 1, 1, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1};
    a[0] = w.a_w; a[1] = w.a_x; a[2] = w.a_y; a[3] = w.a_z;
    b[0] = w.b_w; b[1] = w.b_x; b[2] = w.b_y; b[3] = w.b_z;
    r = '0;
    ov = 1'b0;
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    case (w.op)
      OP_ADD: begin
        r.r_w = clamp32(a[0] + b[0], ov); r.r_x = clamp32(a[1] + b[1], ov);
        r.r_y = clamp32(a[2] + b[2], ov); r.r_z = clamp32(a[3] + b[3], ov);
      end
      OP_SUB: begin
        r.r_w = clamp32(a[0] - b[0], ov); r.r_x = clamp32(a[1] - b[1], ov);
        r.r_y = clamp32(a[2] - b[2], ov); r.r_z = clamp32(a[3] - b[3], ov);
      end
      OP_MUL: begin
        logic signed [31:0] c[4];
        for (int k = 0; k < 4; k++) begin
          acc = 0;
          for (int i = 0; i < 4; i++) begin
            p = a[ai[4*k+i]] * b[bi[4*k+i]];
            acc = sb[4*k+i] ? acc - p : acc + p;
          end
          c[k] = clamp32(round_half_up(acc), ov);
        end
        r.r_w = c[0]; r.r_x = c[1]; r.r_y = c[2]; r.r_z = c[3];
      end
      OP_SCL: begin
        logic signed [199:0] s;
        s = w.scalar_in;
        r.r_w = clamp32(round_half_up(a[0] * s), ov);
        r.r_x = clamp32(round_half_up(a[1] * s), ov);
        r.r_y = clamp32(round_half_up(a[2] * s), ov);
        r.r_z = clamp32(round_half_up(a[3] * s), ov);
      end
      OP_CONJ: begin
        r.r_w = w.a_w; r.r_x = clamp32(-a[1], ov);
        r.r_y = clamp32(-a[2], ov); r.r_z = clamp32(-a[3], ov);
      end
      OP_NORM: begin
        f = round_sqrt(sq);
        if (f == 0) begin
          r.zero_length = 1'b1;
          r.r_w = w.a_w; r.r_x = w.a_x; r.r_y = w.a_y; r.r_z = w.a_z;
        end else begin
          logic signed [31:0] c[4];
          logic signed [199:0] s;
          s = w.scalar_in;
          for (int i = 0; i < 4; i++) begin
            p = a[i] * s;
            neg = p < 0;
            if (neg) p = -p;
            q = (2 * p + f) / (2 * f);
            c[i] = clamp32(neg ? -q : q, ov);
          end
          r.r_w = c[0]; r.r_x = c[1]; r.r_y = c[2]; r.r_z = c[3];
        end
      end
      OP_LEN:  r.scalar_out = clamp32(round_sqrt(sq), ov);
      default: r.scalar_out = clamp32(round_half_up(sq), ov);
    endcase
    r.overflow = ov;
    return r;
  endfunction

  // start stays high after an accept so that words can follow back to back
  task automatic send_word(input qau_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(quat_result(w));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, result_o);
        errors++;
      end else begin
        qau_out_t e;
        e = expected_q.pop_front();
        if (e !== result_o) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, result_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return 32'hffffffff;
      6: return $urandom_range(65535) - 32768;
      7: return ($urandom_range(511) - 256) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic qau_in_t rand_word();
    qau_in_t w;
    w.op = 3'($urandom_range(7));
    w.a_w = edge_val(); w.a_x = edge_val(); w.a_y = edge_val(); w.a_z = edge_val();
    w.b_w = edge_val(); w.b_x = edge_val(); w.b_y = edge_val(); w.b_z = edge_val();
    w.scalar_in = edge_val();
    if ($urandom_range(9) == 0) {w.a_w, w.a_x, w.a_y, w.a_z} = '0;
    return w;
  endfunction

  task automatic test_directed();
    qau_in_t w;
    logic [31:0] vals[4];
    vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000};
    for (int op = 0; op < 8; op++) begin
      for (int v = 0; v < 2; v++) begin
        w.op = 3'(op);
        {w.a_w, w.a_x, w.a_y, w.a_z} = {4{vals[v]}};
        {w.b_w, w.b_x, w.b_y, w.b_z} = {4{vals[v]}};
        w.scalar_in = vals[v];
        send_word(w);
      end
    end
    // normalize of zero length quaternion, and one of length 5
    w = '0;
    w.op = OP_NORM;
    w.scalar_in = 32'h00010000;
    send_word(w);
    w.a_x = 32'h00030000;
    w.a_y = 32'h00040000;
    send_word(w);
    w.op = OP_LEN;
    send_word(w);
    w.op = OP_CONJ;
    w.a_x = 32'h80000000;
    send_word(w);
    w.op = OP_MUL;
    {w.a_w, w.a_x, w.a_y, w.a_z} = {32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000};
    {w.b_w, w.b_x, w.b_y, w.b_z} = {32'h00050000, 32'hfffa0000, 32'h00070000, 32'h00008000};
    send_word(w);
  endtask

  task automatic test_random(input int n, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (n) send_word(rand_word());
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(280, 38);
    test_random(280, 79);
    test_random(290, 0);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (MAX_LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
